@@ rtl/core/prm_pkg.sv @@
// Shared types and constants for the pulse rate meter.
`default_nettype none

package prm_pkg;

  // Field widths
  localparam int unsigned RateW    = 16;
  localparam int unsigned ConfirmW = 8;
  localparam int unsigned DivStepW = $clog2(RateW);

  // Configuration register indexes (byte address = 4 * index)
  localparam logic [1:0] REG_CONFIRM_TICKS  = 2'd0;
  localparam logic [1:0] REG_INTERVAL_LIMIT = 2'd1;
  localparam logic [1:0] REG_RATE_NUMERATOR = 2'd2;

  // Register reset values
  localparam logic [ConfirmW-1:0] CONFIRM_TICKS_RST  = 8'd10;
  localparam logic [RateW-1:0]    INTERVAL_LIMIT_RST = 16'd300;
  localparam logic [RateW-1:0]    RATE_NUMERATOR_RST = 16'd6000;

  // Input mode codes
  localparam logic MODE_TICK = 1'b0;
  localparam logic MODE_EDGE = 1'b1;

  // Sequencer states
  typedef enum logic [1:0] {
    S_IDLE,
    S_DIV,
    S_PUSH
  } state_t;

endpackage

`default_nettype wire

@@ rtl/core/prm_in_if.sv @@
// Input channel: one word per edge or tick event.
`default_nettype none

interface prm_in_if;
  logic valid;
  logic ready;
  logic mode;
  logic pin_level;

  modport source (output valid, output mode, output pin_level, input ready);
  modport sink   (input valid, input mode, input pin_level, output ready);
endinterface

`default_nettype wire

@@ rtl/core/prm_out_if.sv @@
// Result channel: one word per accepted input word.
`default_nettype none

interface prm_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] rate;
  logic        rate_updated;
  logic        armed;

  modport source (output valid, output rate, output rate_updated, output armed, input ready);
  modport sink   (input valid, input rate, input rate_updated, input armed, output ready);
endinterface

`default_nettype wire

@@ rtl/core/pulse_rate_meter_with_confirm_core.sv @@
// Pulse rate meter: edge confirm logic, interval counter and shared serial divider.
`default_nettype none

// Every input word gives exactly one result word. An edge word arms the
// trigger; tick words confirm it over confirm_ticks high samples, and the
// confirming tick latches rate = rate_numerator / interval (a zero interval
// divides by one), restarts the interval counter from that tick and disarms.
// The interval counter saturates at interval_limit. A rate word passes an
// accept, 16 restoring subtract-and-shift steps of the shared divider and a
// transfer to the output register; other words go from accept to transfer.
// The output register lets the next word be accepted while the previous
// result still waits for the sink. The user must write registers over the APB
// port at byte addresses 0, 4 and 8 only while idle; the block does not enforce it.
module pulse_rate_meter_with_confirm_core
  import prm_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  prm_in_if.sink           in_ch,
  prm_out_if.source        out_ch,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [3:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic      [31:0] prdata,
  output logic             pready
);

  // Configuration registers
  logic [ConfirmW-1:0] confirm_ticks;
  logic [RateW-1:0]    interval_limit;
  logic [RateW-1:0]    rate_numerator;

  // Measurement state
  logic                trigger_armed;
  logic [ConfirmW-1:0] confirm_count;
  logic [RateW-1:0]    interval_count;
  logic [RateW-1:0]    rate_value;
  logic                res_updated;

  // Divider registers
  logic [RateW-1:0]    div_rem;
  logic [RateW-1:0]    div_quo;
  logic [RateW-1:0]    div_den;
  logic [DivStepW-1:0] div_step;

  state_t state, state_next;

  logic in_fire, out_load, cfg_write;

  // APB access
  assign pready    = 1'b1;
  assign cfg_write = psel & penable & pwrite;

  always_comb begin
    case (paddr[3:2])
      REG_CONFIRM_TICKS:  prdata = {24'd0, confirm_ticks};
      REG_INTERVAL_LIMIT: prdata = {16'd0, interval_limit};
      REG_RATE_NUMERATOR: prdata = {16'd0, rate_numerator};
      default:            prdata = 32'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      confirm_ticks  <= CONFIRM_TICKS_RST;
      interval_limit <= INTERVAL_LIMIT_RST;
      rate_numerator <= RATE_NUMERATOR_RST;
    end else if (cfg_write) begin
      case (paddr[3:2])
        REG_CONFIRM_TICKS:  confirm_ticks  <= pwdata[ConfirmW-1:0];
        REG_INTERVAL_LIMIT: interval_limit <= pwdata[RateW-1:0];
        REG_RATE_NUMERATOR: rate_numerator <= pwdata[RateW-1:0];
        default: ;
      endcase
    end
  end

  // Decide the word's effect on the confirm and interval state
  logic             is_tick, cnt_below, cnt_equal, measure;
  logic [RateW-1:0] ivl_base;
  logic [RateW:0]   ivl_inc;
  logic [RateW-1:0] ivl_sat;

  always_comb begin
    is_tick   = (in_ch.mode == MODE_TICK);
    cnt_below = (confirm_count < confirm_ticks);
    cnt_equal = (confirm_count == confirm_ticks);
    measure   = is_tick & trigger_armed & cnt_equal & in_ch.pin_level;
    ivl_base  = measure ? '0 : interval_count;
    ivl_inc   = {1'b0, ivl_base} + {{RateW{1'b0}}, 1'b1};
    ivl_sat   = (ivl_inc > {1'b0, interval_limit}) ? interval_limit : ivl_inc[RateW-1:0];
  end

  // Shared subtract unit: one restoring division step
  logic [RateW:0] div_shift, div_diff;

  always_comb begin
    div_shift = {div_rem, div_quo[RateW-1]};
    div_diff  = div_shift - {1'b0, div_den};
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next  = state;
    in_ch.ready = 1'b0;
    out_load    = 1'b0;
    case (state)
      S_IDLE: begin
        in_ch.ready = 1'b1;
        if (in_ch.valid) begin
          state_next = measure ? S_DIV : S_PUSH;
        end
      end
      S_DIV: begin
        if (div_step == '0) begin
          state_next = S_PUSH;
        end
      end
      S_PUSH: begin
        if (!out_ch.valid || out_ch.ready) begin
          out_load   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  assign in_fire = in_ch.valid & in_ch.ready;

  // Update measurement state on an accepted word
  always_ff @(posedge clk) begin
    if (rst) begin
      trigger_armed  <= 1'b0;
      confirm_count  <= '0;
      interval_count <= '0;
      rate_value     <= '0;
      res_updated    <= 1'b0;
    end else begin
      if (in_fire) begin
        res_updated <= measure;
        if (!is_tick) begin
          trigger_armed <= 1'b1;
          confirm_count <= '0;
        end else begin
          interval_count <= ivl_sat;
          if (trigger_armed) begin
            if (cnt_below) begin
              if (in_ch.pin_level) begin
                confirm_count <= confirm_count + ConfirmW'(1);
              end else begin
                trigger_armed <= 1'b0;
              end
            end else if (measure) begin
              trigger_armed <= 1'b0;
            end
          end
        end
      end
      // Latch the quotient after the last step
      if (state == S_DIV && div_step == '0) begin
        rate_value <= div_diff[RateW] ? {div_quo[RateW-2:0], 1'b0}
                                      : {div_quo[RateW-2:0], 1'b1};
      end
    end
  end

  // Load and advance the divider
  always_ff @(posedge clk) begin
    if (rst) begin
      div_step <= '0;
    end else if (in_fire && measure) begin
      div_step <= DivStepW'(RateW - 1);
    end else if (state == S_DIV) begin
      div_step <= div_step - DivStepW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire && measure) begin
      div_rem <= '0;
      div_quo <= rate_numerator;
      div_den <= (interval_count == '0) ? {{(RateW-1){1'b0}}, 1'b1} : interval_count;
    end else if (state == S_DIV) begin
      if (div_diff[RateW]) begin
        div_rem <= div_shift[RateW-1:0];
        div_quo <= {div_quo[RateW-2:0], 1'b0};
      end else begin
        div_rem <= div_diff[RateW-1:0];
        div_quo <= {div_quo[RateW-2:0], 1'b1};
      end
    end
  end

  // Output register: hold the word until the sink takes it
  always_ff @(posedge clk) begin
    if (rst) begin
      out_ch.valid <= 1'b0;
    end else if (out_load) begin
      out_ch.valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_ch.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_ch.rate         <= rate_value;
      out_ch.rate_updated <= res_updated;
      out_ch.armed        <= trigger_armed;
    end
  end

endmodule

`default_nettype wire

@@ test/pulse_rate_meter_with_confirm_core_test.sv @@
// Testbench for the pulse rate meter core: directed table, random edge/tick runs, APB writes.
`timescale 1ns / 1ps

module pulse_rate_meter_with_confirm_core_test;
  import prm_pkg::*;

  localparam int unsigned WatchdogLimit = 2000;
  localparam int unsigned DrainCycles   = 40;
  localparam int unsigned DirectedWords = 27;
  localparam int unsigned PhaseWords    = 254;
  localparam int unsigned NumPhases     = 6;

  typedef struct packed {
    logic [RateW-1:0] rate;
    logic             updated;
    logic             armed;
  } rate_res_t;

  typedef struct packed {
    logic             is_cfg;
    logic [1:0]       idx;
    logic [RateW-1:0] val;
    logic             mode;
    logic             pin;
    logic             typed;
    rate_res_t        want;
  } plan_row_t;

  logic        clk;
  logic        rst;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [3:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  prm_in_if  in_ch ();
  prm_out_if out_ch ();

  pulse_rate_meter_with_confirm_core DUT (
    .clk     (clk),
    .rst     (rst),
    .in_ch   (in_ch),
    .out_ch  (out_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // Meter state and register copies kept by the predictor
  logic                meter_armed;
  logic [ConfirmW-1:0] meter_confirm;
  logic [RateW-1:0]    meter_interval;
  logic [RateW-1:0]    meter_rate;
  logic [ConfirmW-1:0] cfg_confirm;
  logic [RateW-1:0]    cfg_limit;
  logic [RateW-1:0]    cfg_numer;

  rate_res_t   rate_expect_q[$];
  int unsigned err_count;
  int unsigned words_sent;
  int unsigned burst_left;
  int unsigned idle_cycles;

  // Free-running clock
  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Print one mismatch line and count it
  task automatic report_mismatch(input string what, input int got, input int want);
    err_count++;
    $display("MISMATCH %s: got %0d, expected %0d (t=%0t)", what, got, want, $realtime);
  endtask

  // Advance the meter by one word and return the result it gives
  task automatic meter_predict(input logic mode, input logic pin, output rate_res_t res);
    logic [RateW:0]   next_ivl;
    logic [RateW-1:0] divisor;
    res.updated = 1'b0;
    if (mode == MODE_EDGE) begin
      meter_armed   = 1'b1;
      meter_confirm = '0;
    end else begin
      if (meter_armed) begin
        if (meter_confirm < cfg_confirm) begin
          if (pin) begin
            meter_confirm = meter_confirm + 8'd1;
          end else begin
            meter_armed = 1'b0;
          end
        end else if (meter_confirm == cfg_confirm && pin) begin
          // zero interval divides by one
          divisor        = (meter_interval == '0) ? 16'd1 : meter_interval;
          meter_rate     = cfg_numer / divisor;
          meter_interval = '0;
          meter_armed    = 1'b0;
          res.updated    = 1'b1;
        end
      end
      // saturate the interval count at the limit
      next_ivl = {1'b0, meter_interval} + 17'd1;
      if (next_ivl > {1'b0, cfg_limit}) begin
        next_ivl = {1'b0, cfg_limit};
      end
      meter_interval = next_ivl[RateW-1:0];
    end
    res.rate  = meter_rate;
    res.armed = meter_armed;
  endtask

  // Drop valid and hold until every expected word has come back
  task automatic wait_idle();
    @(negedge clk);
    in_ch.valid = 1'b0;
    while (rate_expect_q.size() != 0) @(posedge clk);
  endtask

  // APB write: setup cycle, then access cycle until pready
  task automatic cfg_write(input logic [1:0] idx, input logic [RateW-1:0] val);
    @(negedge clk);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = {idx, 2'b00};
    pwdata  = {16'd0, val};
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    case (idx)
      REG_CONFIRM_TICKS:  cfg_confirm = val[ConfirmW-1:0];
      REG_INTERVAL_LIMIT: cfg_limit   = val;
      REG_RATE_NUMERATOR: cfg_numer   = val;
      default: ;
    endcase
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
  endtask

  // Send one word in bursts with random gaps; queue its expected result
  task automatic send_word(input logic mode, input logic pin, input logic typed,
                           input rate_res_t want);
    int unsigned gap;
    rate_res_t   res;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(1, 12);
      if (gap != 0) begin
        @(negedge clk);
        in_ch.valid = 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    @(negedge clk);
    in_ch.valid     = 1'b1;
    in_ch.mode      = mode;
    in_ch.pin_level = pin;
    do @(posedge clk); while (!in_ch.ready);
    burst_left--;
    words_sent++;
    meter_predict(mode, pin, res);
    rate_expect_q.push_back(typed ? want : res);
  endtask

  function automatic plan_row_t cfg_row(input logic [1:0] idx, input logic [RateW-1:0] val);
    plan_row_t r;
    r        = '0;
    r.is_cfg = 1'b1;
    r.idx    = idx;
    r.val    = val;
    return r;
  endfunction

  function automatic plan_row_t word_row(input logic mode, input logic pin);
    plan_row_t r;
    r      = '0;
    r.mode = mode;
    r.pin  = pin;
    return r;
  endfunction

  function automatic plan_row_t checked_row(input logic mode, input logic pin,
                                            input logic [RateW-1:0] rate,
                                            input logic updated, input logic armed);
    plan_row_t r;
    r       = word_row(mode, pin);
    r.typed = 1'b1;
    r.want  = '{rate: rate, updated: updated, armed: armed};
    return r;
  endfunction

  // Receiver: stall on a pattern whose density is re-drawn at regular intervals
  initial begin
    int unsigned stall_run;
    int unsigned stall_pct;
    int unsigned cyc;
    stall_run = 0;
    stall_pct = 0;
    cyc       = 0;
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      cyc++;
      if (cyc % 300 == 0) begin
        case ($urandom_range(0, 2))
          0:       stall_pct = 0;
          1:       stall_pct = 15;
          default: stall_pct = 50;
        endcase
      end
      if (stall_run != 0) begin
        stall_run--;
        out_ch.ready = 1'b0;
      end else begin
        out_ch.ready = 1'b1;
        if ($urandom_range(0, 99) < stall_pct) begin
          stall_run = $urandom_range(1, 20);
        end
      end
    end
  end

  // Compare each accepted result word with the oldest expectation
  always @(posedge clk) begin
    rate_res_t exp_res;
    if (!rst && out_ch.valid && out_ch.ready) begin
      if (rate_expect_q.size() == 0) begin
        report_mismatch("unexpected result word", 1, 0);
      end else begin
        exp_res = rate_expect_q.pop_front();
        if (out_ch.rate !== exp_res.rate) begin
          report_mismatch("rate", out_ch.rate, exp_res.rate);
        end
        if (out_ch.rate_updated !== exp_res.updated) begin
          report_mismatch("rate_updated", out_ch.rate_updated, exp_res.updated);
        end
        if (out_ch.armed !== exp_res.armed) begin
          report_mismatch("armed", out_ch.armed, exp_res.armed);
        end
      end
    end
  end

  // Watchdog: end the run after too long without any handshake
  initial begin
    idle_cycles = 0;
    while (idle_cycles < WatchdogLimit) begin
      @(posedge clk);
      if (rst || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || psel) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
    end
    $display("Watchdog: no handshake for %0d cycles", WatchdogLimit);
    $display("DONE: errors detected");
    $finish;
  end

  // Main sequence: reset, directed table, random phases, drain
  initial begin
    plan_row_t   plan[$];
    int unsigned phase_end;
    int unsigned phase_mid;
    int unsigned k;
    int unsigned n;
    logic        paused;
    logic [RateW-1:0] pick;

    rst             = 1'b1;
    psel            = 1'b0;
    penable         = 1'b0;
    pwrite          = 1'b0;
    paddr           = '0;
    pwdata          = '0;
    in_ch.valid     = 1'b0;
    in_ch.mode      = MODE_TICK;
    in_ch.pin_level = 1'b0;
    err_count       = 0;
    words_sent      = 0;
    burst_left      = 0;
    meter_armed     = 1'b0;
    meter_confirm   = '0;
    meter_interval  = '0;
    meter_rate      = '0;
    cfg_confirm     = CONFIRM_TICKS_RST;
    cfg_limit       = INTERVAL_LIMIT_RST;
    cfg_numer       = RATE_NUMERATOR_RST;

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed: reset defaults, zero divisor, extremes, confirm count above the limit
    plan = '{
      checked_row(MODE_TICK, 1'b0, 16'd0, 1'b0, 1'b0),
      checked_row(MODE_EDGE, 1'b0, 16'd0, 1'b0, 1'b1),
      word_row(MODE_TICK, 1'b1), word_row(MODE_TICK, 1'b1), word_row(MODE_TICK, 1'b1),
      word_row(MODE_TICK, 1'b1), word_row(MODE_TICK, 1'b1), word_row(MODE_TICK, 1'b1),
      word_row(MODE_TICK, 1'b1), word_row(MODE_TICK, 1'b1), word_row(MODE_TICK, 1'b1),
      word_row(MODE_TICK, 1'b1),
      word_row(MODE_TICK, 1'b1),
      cfg_row(REG_CONFIRM_TICKS, 16'd1),
      cfg_row(REG_INTERVAL_LIMIT, 16'd0),
      word_row(MODE_EDGE, 1'b1),
      word_row(MODE_TICK, 1'b1),
      checked_row(MODE_TICK, 1'b1, 16'd6000, 1'b1, 1'b0),
      cfg_row(REG_RATE_NUMERATOR, 16'hFFFF),
      cfg_row(REG_INTERVAL_LIMIT, 16'hFFFF),
      word_row(MODE_EDGE, 1'b0),
      word_row(MODE_TICK, 1'b1),
      checked_row(MODE_TICK, 1'b1, 16'hFFFF, 1'b1, 1'b0),
      cfg_row(REG_CONFIRM_TICKS, 16'd255),
      cfg_row(REG_RATE_NUMERATOR, 16'd1),
      word_row(MODE_EDGE, 1'b1),
      word_row(MODE_TICK, 1'b1), word_row(MODE_TICK, 1'b1), word_row(MODE_TICK, 1'b1),
      cfg_row(REG_CONFIRM_TICKS, 16'd2),
      word_row(MODE_TICK, 1'b1),
      word_row(MODE_TICK, 1'b0),
      cfg_row(REG_CONFIRM_TICKS, 16'd3),
      word_row(MODE_TICK, 1'b0),
      word_row(MODE_TICK, 1'b1)
    };
    foreach (plan[i]) begin
      if (plan[i].is_cfg) begin
        wait_idle();
        cfg_write(plan[i].idx, plan[i].val);
      end else begin
        send_word(plan[i].mode, plan[i].pin, plan[i].typed, plan[i].want);
      end
    end

    // Random phases, each with fresh register settings
    for (int p = 0; p < NumPhases; p++) begin
      wait_idle();
      case ($urandom_range(0, 3))
        0:       pick = 16'd1;
        1:       pick = 16'd255;
        default: pick = 16'($urandom_range(1, 12));
      endcase
      cfg_write(REG_CONFIRM_TICKS, pick);
      case ($urandom_range(0, 3))
        0:       pick = 16'd1;
        1:       pick = 16'hFFFF;
        default: pick = 16'($urandom_range(1, 400));
      endcase
      if (p == 0) begin
        pick = 16'd1;
      end
      cfg_write(REG_INTERVAL_LIMIT, pick);
      case ($urandom_range(0, 3))
        0:       pick = 16'd1;
        1:       pick = 16'hFFFF;
        default: pick = 16'($urandom_range(1, 65535));
      endcase
      cfg_write(REG_RATE_NUMERATOR, pick);

      phase_end = DirectedWords + (p + 1) * PhaseWords;
      phase_mid = phase_end - PhaseWords / 2;
      paused    = 1'b0;
      while (words_sent < phase_end) begin
        // hold the sender once per phase until the result side drains
        if (!paused && words_sent >= phase_mid) begin
          wait_idle();
          paused = 1'b1;
        end
        if ($urandom_range(0, 9) < 7) begin
          // edge, a run of high ticks around the confirm count, then a random tail
          send_word(MODE_EDGE, 1'($urandom_range(0, 1)), 1'b0, '0);
          case ($urandom_range(0, 3))
            0, 1:    k = cfg_confirm + 1;
            2:       k = cfg_confirm;
            default: k = $urandom_range(0, cfg_confirm);
          endcase
          for (int j = 0; j < k; j++) begin
            send_word(MODE_TICK, 1'b1, 1'b0, '0);
          end
          n = $urandom_range(0, 4);
          for (int j = 0; j < n; j++) begin
            send_word(MODE_TICK, 1'($urandom_range(0, 1)), 1'b0, '0);
          end
        end else begin
          // noise: mostly ticks with random levels, some stray edges
          n = $urandom_range(1, 6);
          for (int j = 0; j < n; j++) begin
            send_word(($urandom_range(0, 3) == 0) ? MODE_EDGE : MODE_TICK,
                      1'($urandom_range(0, 1)), 1'b0, '0);
          end
        end
      end
    end

    // Drain and let any late word show up
    wait_idle();
    repeat (DrainCycles) @(posedge clk);
    if (err_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
